FILE: design/grid_min_path_sum_core_defines.svh
// Assertion macros used by the grid minimum path sum update stage.
`ifndef GRID_MIN_PATH_SUM_CORE_DEFINES_SVH
`define GRID_MIN_PATH_SUM_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk with reset held off.
`define GMPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk with reset held off.
`define GMPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/gmps_pkg.sv
// Package with the widths, register map and shared types of the path sum core.
`timescale 1ns / 1ps

package gmps_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CFG_W  = 11;
    localparam int COST_W = 16;
    localparam int SUM_W  = 32;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Register indexes (byte address is four times the index).
    localparam logic [ADDR_W-3:0] REG_GRID_COLUMNS = 1'b0;
    localparam logic [ADDR_W-3:0] REG_GRID_ROWS    = 1'b1;

    // One cell waiting for its row buffer read to return.
    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [COL_W-1:0]  col;
        logic              first_row;
        logic              first_col;
        logic              last;
        logic              fwd;
        logic [SUM_W-1:0]  fwd_sum;
    } gmps_item_t;

    // Row buffer write issued by the update stage.
    typedef struct packed {
        logic              en;
        logic [COL_W-1:0]  addr;
        logic [SUM_W-1:0]  data;
    } gmps_wr_t;

endpackage

FILE: design/gmps_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module gmps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/gmps_regs.sv
// Configuration registers on the APB-style port, with clamped grid limits.
`timescale 1ns / 1ps

module gmps_regs import gmps_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [COL_W-1:0]  col_last,
    output logic [ROW_W-1:0]  row_last
);

    localparam logic [CFG_W-1:0] COLS_MAX = CFG_W'(MAX_COLUMNS);
    localparam logic [CFG_W-1:0] ROWS_MAX = CFG_W'(MAX_ROWS);

    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_eff;
    logic [CFG_W-1:0] rows_eff;
    logic             wr_en;
    logic [ADDR_W-3:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CFG_W'(1);
            rows_reg <= CFG_W'(1);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_GRID_COLUMNS: cols_reg <= pwdata[CFG_W-1:0];
                REG_GRID_ROWS:    rows_reg <= pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GRID_COLUMNS: prdata = DATA_W'(cols_reg);
            REG_GRID_ROWS:    prdata = DATA_W'(rows_reg);
            default:          prdata = '0;
        endcase
    end

    // A zero count acts as one; a count above the maximum acts as the maximum.
    always_comb
    begin
        if (cols_reg == '0)
            cols_eff = CFG_W'(1);
        else if (cols_reg > COLS_MAX)
            cols_eff = COLS_MAX;
        else
            cols_eff = cols_reg;

        if (rows_reg == '0)
            rows_eff = CFG_W'(1);
        else if (rows_reg > ROWS_MAX)
            rows_eff = ROWS_MAX;
        else
            rows_eff = rows_reg;
    end

    assign col_last = COL_W'(cols_eff - CFG_W'(1));
    assign row_last = ROW_W'(rows_eff - CFG_W'(1));

endmodule

FILE: design/gmps_sched.sv
// Input stage: position counters, row buffer read issue and forwarding capture.
`timescale 1ns / 1ps

module gmps_sched import gmps_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [COST_W-1:0] cell_cost,
    input  logic [COL_W-1:0]  col_last,
    input  logic [ROW_W-1:0]  row_last,
    input  logic              take,
    input  gmps_wr_t          wr,
    output logic              rd_en,
    output logic [COL_W-1:0]  rd_addr,
    output logic              item_valid,
    output gmps_item_t        item
);

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             item_valid_reg;
    logic             item_valid_next;
    gmps_item_t       item_reg;
    logic             accept;
    logic             last_col;
    logic             last_row;

    assign in_stall = item_valid_reg && !take;
    assign accept   = in_valid && !in_stall;
    assign last_col = col_reg >= col_last;
    assign last_row = row_reg >= row_last;

    assign rd_en   = accept;
    assign rd_addr = col_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        if (accept)
            item_valid_next = 1'b1;
        else if (take)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            item_valid_reg <= item_valid_next;
        end
    end

    // The RAM returns the old entry when the update stage writes the same
    // column in the read cycle, so that sum is kept here instead.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cost      <= cell_cost;
            item_reg.col       <= col_reg;
            item_reg.first_row <= row_reg == '0;
            item_reg.first_col <= col_reg == '0;
            item_reg.last      <= last_col && last_row;
            item_reg.fwd       <= wr.en && (wr.addr == col_reg);
            item_reg.fwd_sum   <= wr.data;
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

FILE: design/gmps_calc.sv
// Update stage: saturating add of the lesser neighbor, row buffer write and output register.
`timescale 1ns / 1ps
`include "grid_min_path_sum_core_defines.svh"

module gmps_calc import gmps_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  gmps_item_t       item,
    input  logic [SUM_W-1:0] rd_data,
    output logic             take,
    output gmps_wr_t         wr,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [SUM_W-1:0] path_sum,
    output logic             last_cell
);

    logic [SUM_W-1:0] left_sum_reg;
    logic [SUM_W-1:0] above;
    logic [SUM_W-1:0] base;
    logic [SUM_W:0]   raw_sum;
    logic [SUM_W-1:0] sum;
    logic             fire;
    logic             out_valid_reg;
    logic [SUM_W-1:0] path_sum_reg;
    logic             last_cell_reg;

    assign take  = !out_valid_reg || !out_stall;
    assign fire  = item_valid && take;
    assign above = item.fwd ? item.fwd_sum : rd_data;

    always_comb
    begin
        if (item.first_row && item.first_col)
            base = '0;
        else if (item.first_row)
            base = left_sum_reg;
        else if (item.first_col)
            base = above;
        else
            base = (above < left_sum_reg) ? above : left_sum_reg;
    end

    assign raw_sum = {1'b0, base} + (SUM_W + 1)'(item.cost);
    assign sum     = raw_sum[SUM_W] ? SUM_MAX : raw_sum[SUM_W-1:0];

    assign wr.en   = fire;
    assign wr.addr = item.col;
    assign wr.data = sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_sum_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                left_sum_reg  <= sum;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            path_sum_reg  <= sum;
            last_cell_reg <= item.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign path_sum  = path_sum_reg;
    assign last_cell = last_cell_reg;

    `GMPS_ASSERT_NOW(a_sum_covers_cost, fire, sum >= SUM_W'(item.cost), "sum below cell cost")
    `GMPS_ASSERT_NOW(a_origin_is_cost, fire && item.first_row && item.first_col,
        sum == SUM_W'(item.cost), "top-left cell sum differs from its cost")
    `GMPS_ASSERT_NEXT(a_left_held_on_stall, item_valid && !take,
        left_sum_reg == $past(left_sum_reg), "left sum changed while stalled")

endmodule

FILE: design/grid_min_path_sum_core.sv
// Top level of the streaming grid minimum path sum core.
`timescale 1ns / 1ps

//  Channel   Handshake                    Payload
//  cfg       psel/penable/pwrite/pready   paddr, pwdata, prdata
//  in        in_valid / in_stall          cell_cost
//  out       out_valid / out_stall        path_sum, last_cell
//
//  One word is accepted per cycle while nothing stalls; the edge that accepts a word
//  issues its row buffer read, and the edge at which the update stage takes it loads
//  the add and compare result into the output register, where it is offered.
//  Reset clears the position counters, the left sum and the valid flags; the row
//  buffer needs no clearing pass, since the first row does not use what it reads.
//  A stall on the output holds the update stage, which then stalls the input.

module grid_min_path_sum_core import gmps_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [COST_W-1:0] cell_cost,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [SUM_W-1:0]  path_sum,
    output logic              last_cell
);

    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;
    logic             take;
    gmps_wr_t         wr;
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic [SUM_W-1:0] rd_data;
    logic             item_valid;
    gmps_item_t       item;

    // Register block: holds the grid size and hands on the clamped last indexes.
    gmps_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .col_last (col_last),
        .row_last (row_last)
    );

    // Input stage: tracks the raster position and reads the sum stored above.
    gmps_sched u_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cell_cost  (cell_cost),
        .col_last   (col_last),
        .row_last   (row_last),
        .take       (take),
        .wr         (wr),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .item_valid (item_valid),
        .item       (item)
    );

    // Row buffer: one running path sum per column of the grid.
    gmps_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_COLUMNS)
    ) u_row_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Update stage: picks the lesser neighbor, adds the cost and writes back.
    gmps_calc u_calc (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .rd_data    (rd_data),
        .take       (take),
        .wr         (wr),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .path_sum   (path_sum),
        .last_cell  (last_cell)
    );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the streaming grid minimum path sum core.
`timescale 1ns / 1ps

module tb_top;
    import gmps_pkg::*;

    // Clock, reset and every input of the core start at known values.
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [COST_W-1:0] cell_cost = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [SUM_W-1:0]  path_sum;
    logic              last_cell;

    // One expected output word: the path sum of a cell and its bottom-right flag.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             last;
    } cell_result_t;

    cell_result_t pending_sums[$];

    // Shadow of the configuration registers, raw as written (low 11 bits).
    logic [CFG_W-1:0] cols_reg = CFG_W'(1);
    logic [CFG_W-1:0] rows_reg = CFG_W'(1);

    // Shadow of the core's dynamic programming state.
    logic [SUM_W-1:0] row_buf [MAX_COLUMNS];
    bit               row_written [MAX_COLUMNS];
    logic [SUM_W-1:0] left_acc = '0;
    logic [ROW_W-1:0] row_pos  = '0;
    logic [COL_W-1:0] col_pos  = '0;

    // Traffic shaping controls shared by the stimulus and the receiver.
    bit sender_gaps  = 1'b1;
    bit stall_gaps   = 1'b1;
    bit offering     = 1'b0;
    int hold_request = 0;
    int error_count  = 0;

    grid_min_path_sum_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cell_cost (cell_cost),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .path_sum  (path_sum),
        .last_cell (last_cell)
    );

    always #5 clk = ~clk;

    // Printing is capped so that a badly broken core cannot flood the log,
    // but every mismatch is still counted.
    task automatic report_mismatch(input string detail);
        if (error_count < 40)
            $display("[%0t] MISMATCH: %s", $time, detail);
        error_count++;
    endtask

    // A register value of zero acts as one and anything above the maximum acts
    // as the maximum.
    function automatic int unsigned eff_count(input logic [CFG_W-1:0] raw,
                                              input int unsigned limit);
        if (raw == 0)
            return 1;
        if (raw > limit)
            return limit;
        return 32'(raw);
    endfunction

    // Works out the result word of one accepted cell and advances the shadow
    // state exactly as the core must.
    function automatic void predict_cell(input logic [COST_W-1:0] cost);
        int unsigned      cols_eff;
        int unsigned      rows_eff;
        logic [SUM_W-1:0] above;
        logic [SUM_W-1:0] base;
        logic [SUM_W:0]   wide;
        logic [SUM_W-1:0] sum;
        bit               at_last_col;
        bit               at_last_row;
        cell_result_t     expected;

        cols_eff    = eff_count(cols_reg, MAX_COLUMNS);
        rows_eff    = eff_count(rows_reg, MAX_ROWS);
        above       = row_buf[col_pos];
        at_last_col = int'(col_pos) >= int'(cols_eff) - 1;
        at_last_row = int'(row_pos) >= int'(rows_eff) - 1;

        if (row_pos == 0 && col_pos == 0)
            sum = SUM_W'(cost);
        else
        begin
            // The first row only looks left, the first column only looks up,
            // and every other cell takes the cheaper of the two neighbors.
            if (row_pos == 0)
                base = left_acc;
            else if (col_pos == 0)
                base = above;
            else
                base = (above < left_acc) ? above : left_acc;
            wide = {1'b0, base} + (SUM_W + 1)'(cost);
            sum  = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
        end

        row_buf[col_pos]     = sum;
        row_written[col_pos] = 1'b1;
        left_acc             = sum;

        expected.sum  = sum;
        expected.last = at_last_col && at_last_row;
        pending_sums.push_back(expected);

        if (at_last_col)
        begin
            col_pos = '0;
            row_pos = at_last_row ? '0 : row_pos + 1'b1;
        end
        else
            col_pos = col_pos + 1'b1;
    endfunction

    // Random costs lean on zero, the maximum and small values, so that equal
    // neighbors and extreme sums show up often.
    function automatic logic [COST_W-1:0] next_cost();
        int unsigned pick;

        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        if (pick < 20)
            return '1;
        if (pick < 40)
            return COST_W'($urandom_range(7));
        return COST_W'($urandom);
    endfunction

    // Offers one word and returns at the edge that accepts it. The valid stays
    // high afterwards so that back-to-back words need no extra assignment.
    task automatic send_cell(input logic [COST_W-1:0] cost);
        if (sender_gaps)
            while ($urandom_range(99) < 26)
            begin
                if (offering)
                    in_valid <= 1'b0;
                offering = 1'b0;
                @(posedge clk);
            end
        in_valid  <= 1'b1;
        cell_cost <= cost;
        offering  = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_cell(cost);
    endtask

    task automatic sender_pause();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_sums.size() != 0)
            @(posedge clk);
    endtask

    // Completes the grid in progress so that the next word is the top-left cell.
    task automatic finish_grid();
        while (row_pos != 0 || col_pos != 0)
            send_cell(next_cost());
    endtask

    // Bus transfers run back to back; psel is dropped only by bus_idle.
    task automatic write_reg(input logic [ADDR_W-3:0] idx, input logic [DATA_W-1:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_GRID_COLUMNS)
            cols_reg = word[CFG_W-1:0];
        else if (idx == REG_GRID_ROWS)
            rows_reg = word[CFG_W-1:0];
    endtask

    task automatic read_check(input logic [ADDR_W-3:0] idx, input logic [CFG_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[CFG_W-1:0] !== want)
            report_mismatch($sformatf("register %0d read 0x%0h, wrote 0x%0h",
                                      idx, prdata[CFG_W-1:0], want));
    endtask

    task automatic bus_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Sets a new grid shape once the core has gone idle. When the core is part
    // way down a grid, a wider row would read row buffer entries that nothing
    // has written yet, so the column count is held to what is already filled.
    task automatic set_grid(input logic [DATA_W-1:0] cols_word,
                            input logic [DATA_W-1:0] rows_word);
        int unsigned reach;

        sender_pause();
        wait_drained();
        if (row_pos != 0)
        begin
            reach = col_pos;
            while (reach < MAX_COLUMNS && row_written[reach])
                reach++;
            if (eff_count(cols_word[CFG_W-1:0], MAX_COLUMNS) > reach)
                cols_word = reach;
        end
        write_reg(REG_GRID_COLUMNS, cols_word);
        write_reg(REG_GRID_ROWS, rows_word);
        read_check(REG_GRID_COLUMNS, cols_reg);
        read_check(REG_GRID_ROWS, rows_reg);
        bus_idle();
    endtask

    // Output side: compares every accepted word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_sums.size() == 0)
                report_mismatch($sformatf("unexpected word, path_sum %0d", path_sum));
            else
            begin
                if (path_sum !== pending_sums[0].sum)
                    report_mismatch($sformatf("path_sum %0d, expected %0d",
                                              path_sum, pending_sums[0].sum));
                if (last_cell !== pending_sums[0].last)
                    report_mismatch($sformatf("last_cell %0b, expected %0b (path_sum %0d)",
                                              last_cell, pending_sums[0].last, path_sum));
                void'(pending_sums.pop_front());
            end
        end
    end

    // Receiver: random stalls, or a long counted hold when a test asks for one.
    initial
    begin : receiver
        int stretch;

        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stretch      = hold_request;
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (stretch)
                    @(posedge clk);
            end
            out_stall <= stall_gaps && ($urandom_range(99) < 26);
        end
    end

    // After reset both registers read back as one and every cell is a whole grid.
    task automatic test_single_cell_grids();
        read_check(REG_GRID_COLUMNS, cols_reg);
        read_check(REG_GRID_ROWS, rows_reg);
        bus_idle();
        send_cell('0);
        send_cell('1);
        send_cell(16'h5555);
        send_cell(16'hAAAA);
    endtask

    // A three by two grid with extreme costs and equal neighbors, then a shape
    // of zero by zero that must behave as one by one.
    task automatic test_small_grid();
        set_grid(3, 2);
        send_cell('1);
        send_cell('0);
        send_cell(16'd1);
        send_cell('0);
        send_cell('1);
        send_cell(16'd2);
        set_grid(0, 0);
        send_cell(16'd7);
        send_cell('1);
    endtask

    // The shape changes part way through a grid: narrowing makes the current
    // column the last one, and widening is held to the columns already filled.
    task automatic test_mid_grid_resize();
        set_grid(4, 4);
        repeat (6)
            send_cell(next_cost());
        set_grid(2, 2);
        repeat (3)
            send_cell(next_cost());
        set_grid(5, 3);
        repeat (4)
            send_cell(next_cost());
    endtask

    // Register values past the maximum act as 1024: a whole row of 1024 cells,
    // then a long run down a one-column grid of 1024 rows.
    task automatic test_largest_grids();
        finish_grid();
        set_grid(2047, 0);
        repeat (MAX_COLUMNS)
            send_cell(next_cost());
        set_grid(0, 1100);
        repeat (300)
            send_cell(next_cost());
    endtask

    // A long stretch with neither side idling.
    task automatic test_full_rate();
        set_grid(7, 5);
        finish_grid();
        sender_gaps = 1'b0;
        stall_gaps  = 1'b0;
        repeat (140)
            send_cell(next_cost());
        sender_gaps = 1'b1;
        stall_gaps  = 1'b1;
    endtask

    // The receiver holds off for a long time while words keep coming, so the
    // core fills and stalls its input; then the sender waits for every result.
    task automatic test_backpressure();
        set_grid(6, 4);
        sender_gaps  = 1'b0;
        hold_request = 250;
        repeat (40)
            send_cell(next_cost());
        sender_gaps = 1'b1;
        sender_pause();
        wait_drained();
        repeat (30)
            send_cell(next_cost());
    endtask

    // Random phases: mostly whole small grids with random costs, some partial
    // grids, and now and then an out of range or very large shape.
    task automatic test_random_grids();
        int unsigned       sent;
        int unsigned       pick;
        int unsigned       cells;
        int unsigned       burst;
        logic [DATA_W-1:0] cols_word;
        logic [DATA_W-1:0] rows_word;

        sent = 0;
        while (sent < 300)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                cols_word = $urandom_range(1, 6);
                rows_word = $urandom_range(1, 6);
            end
            else if (pick < 88)
            begin
                cols_word = $urandom_range(1, 40);
                rows_word = $urandom_range(1, 12);
            end
            else if (pick < 94)
            begin
                cols_word = $urandom_range(1) ? 0 : $urandom_range(MAX_COLUMNS + 1, 2047);
                rows_word = $urandom_range(0, 3);
            end
            else
            begin
                cols_word = $urandom_range(0, 6);
                rows_word = $urandom_range(1) ? 0 : $urandom_range(MAX_ROWS, 2047);
            end
            // Bits above the register width must be dropped by the core.
            if ($urandom_range(3) == 0)
                cols_word = cols_word | ($urandom << CFG_W);
            if ($urandom_range(3) == 0)
                rows_word = rows_word | ($urandom << CFG_W);
            set_grid(cols_word, rows_word);

            cells = eff_count(cols_reg, MAX_COLUMNS) * eff_count(rows_reg, MAX_ROWS);
            if (cells <= 48 && $urandom_range(99) < 80)
            begin
                // Finish the grid in progress, then run whole grids.
                finish_grid();
                burst = cells * $urandom_range(1, 3);
            end
            else
                burst = $urandom_range(5, 60);
            repeat (burst)
                send_cell(next_cost());
            sent += burst;
        end
    endtask

    initial
    begin : main
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_cell_grids();
        test_small_grid();
        test_mid_grid_resize();
        test_full_rate();
        test_backpressure();
        test_largest_grids();
        test_random_grids();

        sender_pause();
        wait_drained();
        repeat (20)
            @(posedge clk);
        if (pending_sums.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", pending_sums.size()));
        if (error_count == 0)
            $display("grid_min_path_sum_core test passed");
        else
            $display("grid_min_path_sum_core test failed");
        $finish;
    end

    // A correct run needs well under a tenth of this time.
    initial
    begin : watchdog
        #5_000_000;
        $display("grid_min_path_sum_core test failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/gmps_pkg.sv
design/gmps_ram.sv
design/gmps_regs.sv
design/gmps_sched.sv
design/gmps_calc.sv
design/grid_min_path_sum_core.sv
dv/tb_top.sv
